>>> hw/rtl/gbn_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gbn_pkg
// shared types and constants of the go-back-n sender core
// ---------------------------------------------------------------------------
package gbn_pkg;

    // sequence space, a power of two so that sequence arithmetic wraps
    localparam int SEQ_SPACE = 8;
    localparam int SEQ_W     = $clog2(SEQ_SPACE);
    localparam int CNT_W     = 3;
    localparam int WIN_W     = 3;
    localparam int TMO_W     = 16;
    localparam int TICK_W    = 32;
    localparam int DATA_W    = 8;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 3;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(4);
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(3);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW         = 3'd0,
        KIND_RESENT      = 3'd1,
        KIND_FULL        = 3'd2,
        KIND_ACK_TAKEN   = 3'd3,
        KIND_ACK_IGNORED = 3'd4,
        KIND_IDLE        = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    // operands of the shared subtract / compare unit
    typedef struct packed {
        logic [TICK_W-1:0] a;
        logic [TICK_W-1:0] b;
        logic [TICK_W-1:0] limit;
    } alu_req_t;

    typedef struct packed {
        logic [TICK_W-1:0] diff;
        logic              lt;
        logic              gt;
    } alu_rsp_t;

    // write and read controls of the frame and stamp stores
    typedef struct packed {
        logic              frame_we;
        logic              stamp_we;
        logic [SEQ_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [TICK_W-1:0] wr_stamp;
        logic              frame_re;
        logic [SEQ_W-1:0]  frame_rd_addr;
        logic              stamp_re;
        logic [SEQ_W-1:0]  stamp_rd_addr;
    } store_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/gbn_alu.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gbn_alu
// shared subtract / compare unit: a - b, borrow, and difference above limit
// ---------------------------------------------------------------------------
module gbn_alu (
    input  var gbn_pkg::alu_req_t req,
    output var gbn_pkg::alu_rsp_t rsp
);
    import gbn_pkg::*;

    logic [TICK_W:0] sub_full;

    always_comb begin
        sub_full = {1'b0, req.a} - {1'b0, req.b};
        rsp.diff = sub_full[TICK_W-1:0];
        rsp.lt   = sub_full[TICK_W];
        rsp.gt   = (sub_full[TICK_W-1:0] > req.limit);
    end

endmodule
`default_nettype wire

>>> hw/rtl/gbn_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gbn_store
// frame byte store and send stamp store, one write and one registered read each
// ---------------------------------------------------------------------------
module gbn_store (
    input  var logic                       aclk,
    input  var gbn_pkg::store_ctl_t        ctl,
    output var logic [gbn_pkg::DATA_W-1:0] frame_rd_data,
    output var logic [gbn_pkg::TICK_W-1:0] stamp_rd_data
);
    import gbn_pkg::*;

    logic [DATA_W-1:0] frame_mem [SEQ_SPACE];
    logic [TICK_W-1:0] stamp_mem [SEQ_SPACE];

    always_ff @(posedge aclk) begin
        if (ctl.frame_we) begin
            frame_mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.frame_re) begin
            frame_rd_data <= frame_mem[ctl.frame_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.stamp_we) begin
            stamp_mem[ctl.wr_addr] <= ctl.wr_stamp;
        end
        if (ctl.stamp_re) begin
            stamp_rd_data <= stamp_mem[ctl.stamp_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/go_back_n_sender_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// go_back_n_sender_core
// go-back-n sliding window sender, sequence numbers modulo 8
// ---------------------------------------------------------------------------
// Each request carries one operation in s_tuser: send a byte, take a
// cumulative ack, or advance time by one tick (the unused code is a tick
// that does not advance time). The core takes one request at a time:
// s_tready is high only while the sequencer is idle. A send, an ack or a
// tick that does not time out is accepted, then passes the execute state,
// which shares the subtract / compare unit, and gives one result. A
// tick whose oldest outstanding frame has waited longer than timeout_ticks
// replays all n outstanding frames oldest first, with m_tlast on the final
// one; each frame passes a read state and then an emit state, as the frame
// store has a single read port. Results sit in an output register, so a
// new request is accepted while the last result still waits for m_tready;
// backpressure only stretches the execute or emit state. The user writes
// configuration through cfg_wr_en / cfg_addr / cfg_wr_data only while the
// core is idle (not enforced); the window size keeps cfg_wr_data[2:0].
// ---------------------------------------------------------------------------
module go_back_n_sender_core (
    input  var logic                            aclk,
    input  var logic                            aresetn,
    // configuration write port
    input  var logic                            cfg_wr_en,
    input  var logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  var logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // request channel
    input  var logic                            s_tvalid,
    output var logic                            s_tready,
    input  var logic [gbn_pkg::S_TDATA_W-1:0]   s_tdata,   // payload[7:0], ack_seq[10:8]
    input  var logic [gbn_pkg::OP_W-1:0]        s_tuser,   // opcode[1:0]
    // result channel
    output var logic                            m_tvalid,
    input  var logic                            m_tready,
    output var logic [gbn_pkg::M_TDATA_W-1:0]   m_tdata,   // frame_seq[2:0], frame_data[10:3],
                                                           // in_flight[13:11]
    output var logic [gbn_pkg::KIND_W-1:0]      m_tuser,   // kind[2:0]
    output var logic                            m_tlast
);
    import gbn_pkg::*;

    // sequencer and request registers
    state_t            state_reg,    state_next;
    op_t               op_reg,       op_next;
    logic [DATA_W-1:0] payload_reg,  payload_next;
    logic [SEQ_W-1:0]  ack_reg,      ack_next;

    // configuration
    logic [WIN_W-1:0]  win_size_reg;
    logic [TMO_W-1:0]  timeout_reg;

    // window state
    logic [SEQ_W-1:0]  base_reg,     base_next;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [CNT_W-1:0]  outst_reg,    outst_next;
    logic [TICK_W-1:0] tick_reg,     tick_next;

    // replay walk
    logic [SEQ_W-1:0]  cur_seq_reg,  cur_seq_next;
    logic [CNT_W-1:0]  remain_reg,   remain_next;

    // output register
    logic              m_valid_reg,  m_valid_next;
    kind_t             m_kind_reg,   m_kind_next;
    logic [SEQ_W-1:0]  m_seq_reg,    m_seq_next;
    logic [DATA_W-1:0] m_data_reg,   m_data_next;
    logic              m_last_reg,   m_last_next;
    logic [CNT_W-1:0]  m_infl_reg,   m_infl_next;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    store_ctl_t        store_ctl;
    logic [DATA_W-1:0] frame_rd_data;
    logic [TICK_W-1:0] stamp_rd_data;

    logic              accept;
    logic              out_free;
    logic [WIN_W-1:0]  win_limit;
    logic [SEQ_W-1:0]  ack_dist;

    // field unpacking
    logic [DATA_W-1:0] in_payload;
    logic [SEQ_W-1:0]  in_ack;

    assign in_payload = s_tdata[DATA_W-1:0];
    assign in_ack     = s_tdata[DATA_W+SEQ_W-1:DATA_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // output register can take a new result this cycle
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(M_TDATA_W-CNT_W-DATA_W-SEQ_W)'(0), m_infl_reg, m_data_reg, m_seq_reg};

    // window capped one below the sequence space
    assign win_limit = (win_size_reg > WIN_W'(SEQ_SPACE - 1)) ? WIN_W'(SEQ_SPACE - 1)
                                                              : win_size_reg;
    // distance of the ack from the window base, wraps in the sequence space
    assign ack_dist  = ack_reg - base_reg;

    gbn_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    gbn_store u_store (
        .aclk          (aclk),
        .ctl           (store_ctl),
        .frame_rd_data (frame_rd_data),
        .stamp_rd_data (stamp_rd_data)
    );

    // operand select for the shared unit
    always_comb begin
        alu_req.limit = TICK_W'(timeout_reg);
        case (op_reg)
            OP_SEND: begin
                // room in window: outstanding < limit
                alu_req.a = TICK_W'(outst_reg);
                alu_req.b = TICK_W'(win_limit);
            end
            OP_ACK: begin
                // ack names an outstanding frame: distance < outstanding
                alu_req.a = TICK_W'(ack_dist);
                alu_req.b = TICK_W'(outst_reg);
            end
            default: begin
                // elapsed ticks of the oldest frame against the timeout
                alu_req.a = tick_reg;
                alu_req.b = stamp_rd_data;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        payload_next  = payload_reg;
        ack_next      = ack_reg;
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        outst_next    = outst_reg;
        tick_next     = tick_reg;
        cur_seq_next  = cur_seq_reg;
        remain_next   = remain_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_seq_next    = m_seq_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_infl_next   = m_infl_reg;

        store_ctl.frame_we      = 1'b0;
        store_ctl.stamp_we      = 1'b0;
        store_ctl.wr_addr       = next_seq_reg;
        store_ctl.wr_data       = payload_reg;
        store_ctl.wr_stamp      = tick_reg;
        store_ctl.frame_re      = 1'b0;
        store_ctl.frame_rd_addr = cur_seq_reg;
        // fetch the oldest stamp with the request, base holds until execute
        store_ctl.stamp_re      = accept;
        store_ctl.stamp_rd_addr = base_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next      = op_t'(s_tuser);
                    payload_next = in_payload;
                    ack_next     = in_ack;
                    if (op_t'(s_tuser) == OP_TICK) begin
                        tick_next = tick_reg + TICK_W'(1);
                    end
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_seq_next   = '0;
                    m_data_next  = '0;
                    m_last_next  = 1'b1;
                    m_infl_next  = outst_reg;
                    state_next   = ST_IDLE;
                    case (op_reg)
                        OP_SEND: begin
                            if (alu_rsp.lt) begin
                                store_ctl.frame_we = 1'b1;
                                store_ctl.stamp_we = 1'b1;
                                next_seq_next      = next_seq_reg + SEQ_W'(1);
                                outst_next         = outst_reg + CNT_W'(1);
                                m_kind_next        = KIND_NEW;
                                m_seq_next         = next_seq_reg;
                                m_data_next        = payload_reg;
                                m_infl_next        = outst_reg + CNT_W'(1);
                            end else begin
                                m_kind_next = KIND_FULL;
                            end
                        end
                        OP_ACK: begin
                            if (alu_rsp.lt) begin
                                base_next   = ack_reg + SEQ_W'(1);
                                outst_next  = outst_reg - CNT_W'(ack_dist) - CNT_W'(1);
                                m_kind_next = KIND_ACK_TAKEN;
                                m_infl_next = outst_reg - CNT_W'(ack_dist) - CNT_W'(1);
                            end else begin
                                m_kind_next = KIND_ACK_IGNORED;
                            end
                        end
                        OP_TICK: begin
                            if ((outst_reg != '0) && alu_rsp.gt) begin
                                // timeout: walk the window instead of a single result
                                m_valid_next = m_valid_reg && !m_tready;
                                cur_seq_next = base_reg;
                                remain_next  = outst_reg;
                                state_next   = ST_READ;
                            end else begin
                                m_kind_next = KIND_IDLE;
                            end
                        end
                        default: begin
                            m_kind_next = KIND_IDLE;
                        end
                    endcase
                end
            end

            ST_READ: begin
                store_ctl.frame_re = 1'b1;
                state_next         = ST_EMIT;
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_kind_next        = KIND_RESENT;
                    m_seq_next         = cur_seq_reg;
                    m_data_next        = frame_rd_data;
                    m_last_next        = (remain_reg == CNT_W'(1));
                    m_infl_next        = outst_reg;
                    // restamp the replayed frame
                    store_ctl.stamp_we = 1'b1;
                    store_ctl.wr_addr  = cur_seq_reg;
                    cur_seq_next       = cur_seq_reg + SEQ_W'(1);
                    remain_next        = remain_reg - CNT_W'(1);
                    state_next         = (remain_reg == CNT_W'(1)) ? ST_IDLE : ST_READ;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            base_reg     <= '0;
            next_seq_reg <= '0;
            outst_reg    <= '0;
            tick_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            next_seq_reg <= next_seq_next;
            outst_reg    <= outst_next;
            tick_reg     <= tick_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg <= WINDOW_RESET;
            timeout_reg  <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WIN_SIZE:      win_size_reg <= cfg_wr_data[WIN_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_reg  <= cfg_wr_data[TMO_W-1:0];
                default:           ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        payload_reg <= payload_next;
        ack_reg     <= ack_next;
        cur_seq_reg <= cur_seq_next;
        remain_reg  <= remain_next;
        m_kind_reg  <= m_kind_next;
        m_seq_reg   <= m_seq_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_infl_reg  <= m_infl_next;
    end

    // window bookkeeping stays consistent
    a_seq_window: assert property (@(posedge aclk) disable iff (!aresetn)
        next_seq_reg == SEQ_W'(base_reg + outst_reg))
        else $error("next sequence does not match base plus outstanding");

    // one request at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while the previous one is still at work");

    // a new frame grows the window by one
    a_new_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && op_reg == OP_SEND && out_free && alu_rsp.lt)
        |=> outst_reg == CNT_W'($past(outst_reg) + CNT_W'(1)))
        else $error("new frame did not grow the window");

    // the final replayed frame is the newest outstanding one
    a_replay_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg && m_kind_reg == KIND_RESENT)
        |-> m_seq_reg == SEQ_W'(base_reg + outst_reg - CNT_W'(1)))
        else $error("replay ended on a frame other than the newest");

endmodule
`default_nettype wire

>>> bench/gbn_sender_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbn_sender_checker
// watches both channels and the register port of the go-back-n sender,
// predicts every result of each accepted request and compares them in order
// ---------------------------------------------------------------------------
module gbn_sender_checker (
    input  var logic                           aclk,
    input  var logic                           aresetn,
    input  var logic                           cfg_wr_en,
    input  var logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  var logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  var logic                           s_tvalid,
    input  var logic                           s_tready,
    input  var logic [gbn_pkg::S_TDATA_W-1:0]  s_tdata,
    input  var logic [gbn_pkg::OP_W-1:0]       s_tuser,
    input  var logic                           m_tvalid,
    input  var logic                           m_tready,
    input  var logic [gbn_pkg::M_TDATA_W-1:0]  m_tdata,
    input  var logic [gbn_pkg::KIND_W-1:0]     m_tuser,
    input  var logic                           m_tlast,
    output var int                             fail_count,
    output var int                             pending,
    output var int                             resend_count,
    output var logic [gbn_pkg::SEQ_W-1:0]      pred_base,
    output var logic [gbn_pkg::CNT_W-1:0]      pred_in_flight
);
    import gbn_pkg::*;

    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data;
        logic              last;
        logic [CNT_W-1:0]  in_flight;
    } frame_result_t;

    frame_result_t expected_q[$];

    logic [WIN_W-1:0]  win_size;
    logic [TMO_W-1:0]  timeout_lim;
    logic [SEQ_W-1:0]  base_seq;
    logic [SEQ_W-1:0]  next_seq;
    logic [CNT_W-1:0]  unacked;
    logic [TICK_W-1:0] tick_count;
    logic [DATA_W-1:0] frame_mem [SEQ_SPACE];
    logic [TICK_W-1:0] stamp_mem [SEQ_SPACE];
    int                mismatches;
    int                resends;

    task automatic add_expected(input kind_t k, input logic [SEQ_W-1:0] sq,
                                input logic [DATA_W-1:0] d, input logic lst);
        frame_result_t r;
        r.kind      = k;
        r.seq       = sq;
        r.data      = d;
        r.last      = lst;
        r.in_flight = unacked;
        expected_q.push_back(r);
    endtask

    task automatic predict_request(input op_t op, input logic [DATA_W-1:0] pay,
                                   input logic [SEQ_W-1:0] ack);
        logic [WIN_W-1:0]  lim;
        logic [SEQ_W-1:0]  gap;
        logic [SEQ_W-1:0]  sq;
        logic [TICK_W-1:0] elapsed;
        int                n;
        case (op)
            OP_SEND: begin
                lim = (win_size > WIN_W'(SEQ_SPACE - 1)) ? WIN_W'(SEQ_SPACE - 1) : win_size;
                if (unacked < lim) begin
                    sq            = next_seq;
                    frame_mem[sq] = pay;
                    stamp_mem[sq] = tick_count;
                    next_seq      = next_seq + 1'b1;
                    unacked       = unacked + 1'b1;
                    add_expected(KIND_NEW, sq, pay, 1'b1);
                end else begin
                    add_expected(KIND_FULL, '0, '0, 1'b1);
                end
            end
            OP_ACK: begin
                // distance from the window base, wraps with the sequence space
                gap = ack - base_seq;
                if (gap < unacked) begin
                    base_seq = ack + 1'b1;
                    unacked  = unacked - gap - 1'b1;
                    add_expected(KIND_ACK_TAKEN, '0, '0, 1'b1);
                end else begin
                    add_expected(KIND_ACK_IGNORED, '0, '0, 1'b1);
                end
            end
            OP_TICK: begin
                tick_count = tick_count + 1'b1;
                elapsed    = tick_count - stamp_mem[base_seq];
                if (unacked != 0 && elapsed > TICK_W'(timeout_lim)) begin
                    n = unacked;
                    for (int i = 0; i < n; i++) begin
                        sq            = base_seq + SEQ_W'(i);
                        stamp_mem[sq] = tick_count;
                        add_expected(KIND_RESENT, sq, frame_mem[sq], i == n - 1);
                        resends++;
                    end
                end else begin
                    add_expected(KIND_IDLE, '0, '0, 1'b1);
                end
            end
            default: add_expected(KIND_IDLE, '0, '0, 1'b1);
        endcase
    endtask

    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (!aresetn) begin
            win_size    = WINDOW_RESET;
            timeout_lim = TIMEOUT_RESET;
            base_seq    = '0;
            next_seq    = '0;
            unacked     = '0;
            tick_count  = '0;
            mismatches  = 0;
            resends     = 0;
            for (int i = 0; i < SEQ_SPACE; i++) begin
                frame_mem[i] = '0;
                stamp_mem[i] = '0;
            end
            expected_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_WIN_SIZE) begin
                    win_size = cfg_wr_data[WIN_W-1:0];
                end else if (cfg_addr == CFG_TIMEOUT_TICKS) begin
                    timeout_lim = cfg_wr_data[TMO_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got.kind      = kind_t'(m_tuser);
                got.seq       = m_tdata[2:0];
                got.data      = m_tdata[10:3];
                got.last      = m_tlast;
                got.in_flight = m_tdata[13:11];
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with none expected: kind %0d seq %0d data %02h",
                                 $time, got.kind, got.seq, got.data);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.seq !== want.seq ||
                        got.data !== want.data || got.last !== want.last ||
                        got.in_flight !== want.in_flight) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: mismatch, want kind %0d seq %0d data %02h",
                                      " last %0b inflight %0d"},
                                     $time, want.kind, want.seq, want.data, want.last,
                                     want.in_flight);
                            $display({"%0t:             got kind %0d seq %0d data %02h",
                                      " last %0b inflight %0d"},
                                     $time, got.kind, got.seq, got.data, got.last,
                                     got.in_flight);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_request(op_t'(s_tuser), s_tdata[7:0], s_tdata[10:8]);
            end
        end
        fail_count     <= mismatches;
        pending        <= expected_q.size();
        resend_count   <= resends;
        pred_base      <= base_seq;
        pred_in_flight <= unacked;
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// drives the go-back-n sender core with requests and register writes
// ---------------------------------------------------------------------------
// A directed opening walks through idle ticks, the unused opcode, ignored and
// taken acks, a full window and go-back replays, up to a seven-frame replay.
// Random requests follow under several window / timeout settings, zero and
// maximum window included. The checker beside the core predicts and compares
// every result; this module only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb;
    import gbn_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 30;
    localparam int NUM_PHASES   = 6;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [OP_W-1:0]       s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    int                    fail_count;
    int                    pending;
    int                    resend_count;
    logic [SEQ_W-1:0]      pred_base;
    logic [CNT_W-1:0]      pred_in_flight;

    // written only by the request process
    int                    n_sent  = 0;
    logic                  no_idle = 1'b0;
    // written only by the result-side process
    logic                  held    = 1'b0;
    // written only by the run limit process
    int                    cycles  = 0;

    // window / timeout pairs of the random phases, raw values written as is
    logic [CFG_DATA_W-1:0] phase_win [NUM_PHASES] = '{16'd0, 16'hFFF9, 16'd3,
                                                      16'd7, 16'd6, 16'd5};
    logic [CFG_DATA_W-1:0] phase_tmo [NUM_PHASES] = '{16'd1, 16'd2, 16'd65535,
                                                      16'd1, 16'd4, 16'd3};

    go_back_n_sender_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // payload[7:0], ack_seq[10:8]
        .s_tuser     (s_tuser),     // opcode[1:0]
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // frame_seq[2:0], frame_data[10:3], in_flight[13:11]
        .m_tuser     (m_tuser),     // kind[2:0]
        .m_tlast     (m_tlast)
    );

    gbn_sender_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .pending        (pending),
        .resend_count   (resend_count),
        .pred_base      (pred_base),
        .pred_in_flight (pred_in_flight)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one request, sometimes after a random gap, and wait for the handshake
    task automatic offer_request(input op_t op, input logic [DATA_W-1:0] pay,
                                 input logic [SEQ_W-1:0] ack);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({ack, pay});
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // register write once the core has drained every result
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sends, acks, ticks and the unused opcode; acks mostly land inside the window
    task automatic random_request();
        op_t              op;
        logic [DATA_W-1:0] pay;
        logic [SEQ_W-1:0]  ack;
        int               pick;
        pick = $urandom_range(0, 99);
        pay  = $urandom_range(0, 255);
        ack  = $urandom_range(0, 7);
        if (pick < 45) begin
            op = OP_SEND;
        end else if (pick < 75) begin
            op = OP_ACK;
            if (pred_in_flight != 0 && $urandom_range(0, 9) < 8) begin
                ack = pred_base + SEQ_W'($urandom_range(0, pred_in_flight - 1));
            end
        end else if (pick < 96) begin
            op = OP_TICK;
        end else begin
            op = OP_NOP;
        end
        offer_request(op, pay, ack);
    endtask

    // result side: random stalls, plus one long hold-off that backs up the core
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!held && n_sent >= 130) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // request side and verdict
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: window 4, timeout 3
        offer_request(OP_TICK, 8'h00, 3'd0);      // nothing outstanding, tick idle
        offer_request(OP_NOP,  8'hFF, 3'd7);      // unused opcode
        offer_request(OP_ACK,  8'h00, 3'd0);      // ack with nothing outstanding
        offer_request(OP_SEND, 8'h00, 3'd7);
        offer_request(OP_SEND, 8'hFF, 3'd0);
        offer_request(OP_SEND, 8'hA5, 3'd5);
        offer_request(OP_SEND, 8'h5A, 3'd2);
        offer_request(OP_SEND, 8'h3C, 3'd0);      // window full, byte dropped
        offer_request(OP_ACK,  8'h00, 3'd6);      // outside window
        offer_request(OP_ACK,  8'hFF, 3'd1);      // releases frames 0 and 1
        repeat (4) offer_request(OP_TICK, 8'h00, 3'd0);  // last one times out
        offer_request(OP_ACK,  8'h00, 3'd3);      // window empty again

        // widest window, zero timeout: a full replay of seven frames
        write_reg(CFG_WIN_SIZE, 16'd7);
        write_reg(CFG_TIMEOUT_TICKS, 16'd0);
        for (int i = 0; i < 7; i++) begin
            offer_request(OP_SEND, DATA_W'($urandom_range(0, 255)), 3'd0);
        end
        offer_request(OP_SEND, 8'h77, 3'd0);      // full at seven
        offer_request(OP_TICK, 8'h00, 3'd0);
        offer_request(OP_ACK,  8'h00, 3'd2);      // cumulative ack of all seven

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_WIN_SIZE, phase_win[p]);
            write_reg(CFG_TIMEOUT_TICKS, phase_tmo[p]);
            // final phase runs back to back on both sides
            if (p == NUM_PHASES - 1) begin
                no_idle = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_request();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d requests over eight window/timeout settings, %0d frames replayed",
                 n_sent, resend_count);
        $display("including zero and full windows and one long result-side hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
